### hdl/spq_pkg.sv
// Package for the sorted-insert priority queue.
// Holds the input and result beat types and the operation codes.
// No dependencies.
`default_nettype none

package spq_pkg;

    // Operation codes carried in the mode field of an input beat.
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // Width of the reported entry count.
    localparam int COUNT_W = 5;

    // One input beat.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
    } t_in;

    // One result beat.
    typedef struct packed {
        logic signed [31:0]   head_value;
        logic [COUNT_W-1:0]   entry_count;
        logic                 is_empty;
        logic                 is_full;
        logic                 rejected;
    } t_out;

endpackage

`default_nettype wire

### hdl/spq_ram.sv
// Entry store of the priority queue: one write port and one registered read port.
// Depends on nothing but its DEPTH parameter.
`default_nettype none

module spq_ram #(
    parameter int  DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [AW-1:0]      i_waddr,
    input  wire logic signed [31:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [AW-1:0]      i_raddr,
    output logic signed [31:0]      o_rdata
);

    logic signed [31:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/sorted_insert_priority_queue.sv
// A push walks back from the tail: it reads the entry ahead of the gap (S_PRD), then compares and
// writes (S_PCMP) for each entry the new value moves back, and writes the head (S_PINS) when it outranks
// all; a pop reads (S_QRD) and moves forward (S_QWR) each entry that stays. Every beat ends in S_FIN.
// Throughput: one beat at a time; a new beat is taken while a finished result still waits.
// Reset (synchronous, active low) empties the queue and sets max_first to 1.
// Depends on spq_pkg and spq_ram.
`default_nettype none

module sorted_insert_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_data,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire spq_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output spq_pkg::t_out      o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PRD  = 7'b0000010,
        S_PCMP = 7'b0000100,
        S_PINS = 7'b0001000,
        S_QRD  = 7'b0010000,
        S_QWR  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_pos, n_pos;
    logic signed [31:0] r_val, n_val;
    logic signed [31:0] r_head, n_head;
    logic               r_rej, n_rej;
    logic               r_max_first;
    logic               r_out_valid, n_out_valid;
    spq_pkg::t_out      r_out, n_out;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wdata;
    logic               w_re;
    logic [AW-1:0]      w_raddr;
    logic signed [31:0] w_rdata;
    logic               w_outranks;
    logic               w_accept;
    logic [31:0]        w_count_ext;

    spq_ram #(
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Single compare, for either order: the new value strictly outranks the entry just read.
    assign w_outranks = r_max_first ? (r_val > w_rdata) : (r_val < w_rdata);

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_count_ext = 32'(r_count);

    // Sequencer: walks the store one entry at a time, a read state and then a write state per entry.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_val       = r_val;
        n_head      = r_head;
        n_rej       = r_rej;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_pos;
        w_wdata     = r_val;
        w_re        = 1'b0;
        w_raddr     = r_pos;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_val = i_in_data.value;
                    n_rej = 1'b0;
                    if (i_in_data.mode == spq_pkg::MODE_PUSH) begin
                        if (r_count == CW'(DEPTH)) begin
                            n_rej   = 1'b1;
                            n_state = S_FIN;
                        end else if (r_count == '0) begin
                            // First entry lands at the head directly.
                            w_we    = 1'b1;
                            w_waddr = '0;
                            w_wdata = i_in_data.value;
                            n_head  = i_in_data.value;
                            n_count = r_count + CW'(1);
                            n_state = S_FIN;
                        end else begin
                            n_pos   = r_count[AW-1:0];
                            n_state = S_PRD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_rej   = 1'b1;
                            n_state = S_FIN;
                        end else if (r_count == CW'(1)) begin
                            n_count = '0;
                            n_state = S_FIN;
                        end else begin
                            n_pos   = AW'(1);
                            n_state = S_QRD;
                        end
                    end
                end
            end
            S_PRD: begin
                // Read the entry just ahead of the gap.
                w_re    = 1'b1;
                w_raddr = r_pos - AW'(1);
                n_state = S_PCMP;
            end
            S_PCMP: begin
                w_we    = 1'b1;
                w_waddr = r_pos;
                if (w_outranks) begin
                    // Move the entry back one slot and keep walking.
                    w_wdata = w_rdata;
                    n_pos   = r_pos - AW'(1);
                    n_state = (r_pos == AW'(1)) ? S_PINS : S_PRD;
                end else begin
                    w_wdata = r_val;
                    n_count = r_count + CW'(1);
                    n_state = S_FIN;
                end
            end
            S_PINS: begin
                // The new value outranks everything held: it becomes the head.
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_val;
                n_head  = r_val;
                n_count = r_count + CW'(1);
                n_state = S_FIN;
            end
            S_QRD: begin
                w_re    = 1'b1;
                w_raddr = r_pos;
                n_state = S_QWR;
            end
            S_QWR: begin
                // Move one entry forward; the first one moved is the new head.
                w_we    = 1'b1;
                w_waddr = r_pos - AW'(1);
                w_wdata = w_rdata;
                if (r_pos == AW'(1)) begin
                    n_head = w_rdata;
                end
                if ((CW + 1)'(r_pos) + (CW + 1)'(1) == (CW + 1)'(r_count)) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end else begin
                    n_pos   = r_pos + AW'(1);
                    n_state = S_QRD;
                end
            end
            S_FIN: begin
                // Load the result beat once the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.head_value     = (r_count == '0) ? 32'sd0 : r_head;
                    n_out.entry_count    = w_count_ext[spq_pkg::COUNT_W-1:0];
                    n_out.is_empty       = (r_count == '0);
                    n_out.is_full        = (r_count == CW'(DEPTH));
                    n_out.rejected       = r_rej;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_max_first <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_max_first <= i_cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_head <= n_head;
        r_rej  <= n_rej;
        r_out  <= n_out;
    end

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above capacity");

    // The insert walk never compares with a gap at the head.
    a_walk_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PCMP || r_state == S_PRD) |-> r_pos != '0)
        else $error("insert walk reached slot zero");

    // An accepted beat always starts work.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state != S_IDLE)
        else $error("accepted beat did not start");

    // A pop walk ends inside the held entries.
    a_pop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QWR) |-> (CW + 1)'(r_pos) < (CW + 1)'(r_count))
        else $error("pop walk beyond held entries");

endmodule

`default_nettype wire

### verif/tb.sv
// Testbench for the sorted-insert priority queue: push and pop beats with random gaps,
// a model of the queue that predicts every result beat, and a field-by-field check.
// Depends on spq_pkg and sorted_insert_priority_queue.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    // Long receiver hold used to fill the block and stall its input.
    localparam int LONG_HOLD = 300;
    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Drain time after the last result, a little above the longest push latency.
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_PRINTS = 60;
    localparam int PHASE_BEATS = 150;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_cfg_we;
    logic          i_cfg_data;
    logic          i_in_valid;
    logic          o_in_ready;
    spq_pkg::t_in  i_in_data;
    logic          o_out_valid;
    logic          i_out_ready;
    spq_pkg::t_out o_out_data;

    // Model of the queue contents and the ordering register.
    logic signed [31:0] model_slots [DEPTH];
    int   model_count = 0;
    logic model_max_first = 1'b1;

    // Predicted status beats, oldest first.
    spq_pkg::t_out expected_status_q [$];

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;

    // Idling controls shared by the sender, the receiver and the tests.
    bit in_idling = 1'b1;
    bit out_idling = 1'b1;
    bit hold_req = 1'b0;

    sorted_insert_priority_queue #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Free-running clock, 8 ns period.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_PRINTS) begin
            $display("mismatch at %0t ns, result %0d: %s", $realtime, n_checked, msg);
        end
    endtask

    // Applies one beat to the queue model and returns the status it should report.
    function automatic spq_pkg::t_out queue_model_step(input spq_pkg::t_in beat);
        spq_pkg::t_out res;
        int pos;
        res.rejected = 1'b0;
        if (beat.mode == spq_pkg::MODE_PUSH) begin
            if (model_count >= DEPTH) begin
                res.rejected = 1'b1;
            end else begin
                // Walk from the tail, moving back every entry the new value strictly outranks.
                pos = model_count;
                while (pos > 0 && (model_max_first ? beat.value > model_slots[pos-1]
                                                   : beat.value < model_slots[pos-1])) begin
                    model_slots[pos] = model_slots[pos-1];
                    pos--;
                end
                model_slots[pos] = beat.value;
                model_count++;
            end
        end else begin
            if (model_count == 0) begin
                res.rejected = 1'b1;
            end else begin
                for (int k = 1; k < model_count; k++) begin
                    model_slots[k-1] = model_slots[k];
                end
                model_count--;
            end
        end
        res.head_value  = (model_count > 0) ? model_slots[0] : 32'sd0;
        res.entry_count = spq_pkg::COUNT_W'(model_count);
        res.is_empty    = (model_count == 0);
        res.is_full     = (model_count == DEPTH);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Values biased towards ties and extremes, the rest fully random.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return int'($urandom_range(0, 8)) - 4;
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Checks each accepted result beat, then records the prediction for each accepted input beat.
    always @(posedge i_clk) begin : status_monitor
        spq_pkg::t_out want;
        if (!i_rst_n) begin
            model_count = 0;
            model_max_first = 1'b1;
            expected_status_q.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_status_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = expected_status_q.pop_front();
                    if (o_out_data.head_value !== want.head_value)
                        report_mismatch($sformatf("head_value got %0d expected %0d",
                                                  o_out_data.head_value, want.head_value));
                    if (o_out_data.entry_count !== want.entry_count)
                        report_mismatch($sformatf("entry_count got %0d expected %0d",
                                                  o_out_data.entry_count, want.entry_count));
                    if (o_out_data.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty got %b expected %b",
                                                  o_out_data.is_empty, want.is_empty));
                    if (o_out_data.is_full !== want.is_full)
                        report_mismatch($sformatf("is_full got %b expected %b",
                                                  o_out_data.is_full, want.is_full));
                    if (o_out_data.rejected !== want.rejected)
                        report_mismatch($sformatf("rejected got %b expected %b",
                                                  o_out_data.rejected, want.rejected));
                    n_checked++;
                end
            end
            if (i_cfg_we) begin
                model_max_first = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                expected_status_q.push_back(queue_model_step(i_in_data));
            end
        end
    end

    // Result side: random stalls, plus a long hold when a test requests one.
    initial begin : result_sink
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (stall_left == 0 && out_idling && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("[sorted_insert_priority_queue] ERROR");
        $finish;
    end

    // Offers one input beat, after an optional gap, and waits until it is taken.
    task automatic send_beat(input spq_pkg::t_in beat);
        int gap;
        gap = in_idling ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    // Stops offering beats and waits until every predicted result has been checked.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (n_checked != n_sent) @(posedge i_clk);
    endtask

    // Writes the ordering register once the queue has nothing in flight.
    task automatic write_order(input logic max_first);
        wait_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= max_first;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // A pop on the empty queue is refused.
    task automatic test_pop_on_empty();
        send_beat(spq_pkg::t_in'{spq_pkg::MODE_POP, 32'sh7fffffff});
    endtask

    // Fill to capacity with extremes and ties, overflow once, then take a few off the head.
    task automatic test_fill_and_overflow();
        logic signed [31:0] fill_vals [DEPTH] = '{
            32'sd5, 32'sh7fffffff, 32'sh80000000, 32'sd0, -32'sd1, 32'sd5, 32'sd1,
            32'sh7fffffff, 32'sh80000000, -32'sd5, 32'sd5, 32'sd100, -32'sd100,
            32'sd0, 32'sd2, -32'sd1};
        foreach (fill_vals[k]) begin
            send_beat(spq_pkg::t_in'{spq_pkg::MODE_PUSH, fill_vals[k]});
        end
        send_beat(spq_pkg::t_in'{spq_pkg::MODE_PUSH, 32'sd7});
        repeat (3) send_beat(spq_pkg::t_in'{spq_pkg::MODE_POP, $urandom});
    endtask

    // Switch to smallest-first while entries are held; later pushes meet the old order.
    task automatic test_order_switch_held();
        write_order(1'b0);
        send_beat(spq_pkg::t_in'{spq_pkg::MODE_PUSH, -32'sd7});
        send_beat(spq_pkg::t_in'{spq_pkg::MODE_PUSH, 32'sd5});
        send_beat(spq_pkg::t_in'{spq_pkg::MODE_PUSH, 32'sh80000000});
    endtask

    // Random phases, each with its own order, push rate and idling pattern.
    task automatic test_random_mix(input int n_phases);
        for (int p = 0; p < n_phases; p++) begin
            int push_pct;
            write_order(p % 2 == 0);
            in_idling  = ($urandom_range(0, 3) != 0);
            out_idling = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: push_pct = 30;
                1: push_pct = 50;
                default: push_pct = 75;
            endcase
            repeat (PHASE_BEATS) begin
                send_beat(spq_pkg::t_in'{($urandom_range(1, 100) <= push_pct)
                                             ? spq_pkg::MODE_PUSH : spq_pkg::MODE_POP,
                                         pick_value()});
            end
        end
    endtask

    // Receiver holds off for a long stretch while beats keep coming, so the input stalls.
    task automatic test_output_backpressure();
        in_idling = 1'b0;
        hold_req = 1'b1;
        repeat (40) begin
            send_beat(spq_pkg::t_in'{($urandom_range(0, 3) != 0)
                                         ? spq_pkg::MODE_PUSH : spq_pkg::MODE_POP,
                                     pick_value()});
        end
        in_idling = 1'b1;
    endtask

    // Test sequence.
    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_pop_on_empty();
        test_fill_and_overflow();
        test_order_switch_held();
        test_random_mix(6);
        test_output_backpressure();
        test_random_mix(6);

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (expected_status_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_status_q.size()));
        end
        if (n_errors == 0) begin
            $display("[sorted_insert_priority_queue] OK");
        end else begin
            $display("[sorted_insert_priority_queue] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sorted_insert_priority_queue.f
hdl/spq_pkg.sv
hdl/spq_ram.sv
hdl/sorted_insert_priority_queue.sv
verif/tb.sv
